// ===== src/sgd_matrix_factor_trainer_macros.svh =====
// Assertion helpers for the top-level RTL
`ifndef SGD_MATRIX_FACTOR_TRAINER_MACROS_SVH
`define SGD_MATRIX_FACTOR_TRAINER_MACROS_SVH
`define SMF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/smf_pkg.sv =====
`default_nettype none
package smf_pkg;
    typedef enum logic [2:0] {
        KIND_RATE    = 3'd0,
        KIND_WR_USER = 3'd1,
        KIND_WR_ITEM = 3'd2,
        KIND_WR_GLOB = 3'd3,
        KIND_RD_USER = 3'd4,
        KIND_RD_ITEM = 3'd5,
        KIND_RD_GLOB = 3'd6,
        KIND_NONE    = 3'd7
    } kind_t;

    localparam logic [1:0] CFG_LR   = 2'd0;
    localparam logic [1:0] CFG_REG  = 2'd1;
    localparam logic [1:0] CFG_NFEAT = 2'd2;
    localparam logic [1:0] CFG_BIAS = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RDWAIT,
        ST_BIASRD,
        ST_DOT,
        ST_PRED,
        ST_ERR,
        ST_BIASUPD,
        ST_UPD,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input item
        logic mem_access;  // write or read for host access kinds
        logic bias_rd;     // read row biases
        logic dot_clr;
        logic dot_step;    // issue one feature read / accumulate
        logic pred;
        logic err;
        logic bias_upd;
        logic upd_step;    // update pass one feature
        logic result;      // latch result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rate_ok;     // rating kind with valid indices
        logic host_op;     // write/read kind
        logic dot_last;
        logic upd_last;
        logic dot_empty;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        if (x > 72'sd2147483647) return 32'sh7fffffff;
        if (x < -72'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== src/smf_ctrl.sv =====
`default_nettype none
module smf_ctrl import smf_pkg::*; (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  in_fire,
    input  wire  out_busy,
    input  stat_t st,
    output cmd_t cmd,
    output logic busy
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = ST_ACCESS;
            ST_ACCESS: begin
                if (st.rate_ok) state_next = ST_BIASRD;
                else if (st.host_op) state_next = ST_RDWAIT;
                else state_next = ST_DONE;
            end
            ST_RDWAIT:  state_next = ST_DONE;
            ST_BIASRD:  state_next = st.dot_empty ? ST_PRED : ST_DOT;
            ST_DOT:     if (st.dot_last) state_next = ST_PRED;
            ST_PRED:    state_next = ST_ERR;
            ST_ERR:     state_next = ST_BIASUPD;
            ST_BIASUPD: state_next = st.dot_empty ? ST_DONE : ST_UPD;
            ST_UPD:     if (st.upd_last) state_next = ST_DONE;
            ST_DONE:    if (!out_busy) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.load = (state_reg == ST_IDLE) && in_fire;
        unique case (state_reg)
            ST_ACCESS:  cmd.mem_access = 1'b1;
            ST_BIASRD:  begin cmd.bias_rd = 1'b1; cmd.dot_clr = 1'b1; end
            ST_DOT:     cmd.dot_step = 1'b1;
            ST_PRED:    cmd.pred = 1'b1;
            ST_ERR:     cmd.err = 1'b1;
            ST_BIASUPD: cmd.bias_upd = 1'b1;
            ST_UPD:     cmd.upd_step = 1'b1;
            ST_DONE:    cmd.result = !out_busy;
            default:    ;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

// ===== src/smf_datapath.sv =====
`default_nettype none
module smf_datapath import smf_pkg::*; #(
    parameter int USERS = 4096,
    parameter int ITEMS = 4096,
    parameter int MAX_FEATURES = 64
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  cmd_t              cmd,
    output stat_t             st,
    input  wire  [2:0]        kind,
    input  wire  [11:0]       user_index,
    input  wire  [11:0]       item_index,
    input  wire  [6:0]        feature_index,
    input  wire signed [31:0] write_value,
    input  wire signed [31:0] score,
    input  wire  [15:0]       lr,
    input  wire  [15:0]       rg,
    input  wire  [6:0]        nfeat,
    input  wire               use_bias,
    output logic signed [31:0] res_pred,
    output logic signed [31:0] res_err,
    output logic signed [31:0] res_read
);
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW = $clog2(MAX_FEATURES + 1);
    localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int IW = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam int UAW = UW + FW;
    localparam int IAW = IW + FW;

    logic signed [31:0] umem [USERS*MAX_FEATURES];
    logic signed [31:0] imem [ITEMS*MAX_FEATURES];
    logic signed [31:0] ubmem [USERS];
    logic signed [31:0] ibmem [ITEMS];
    logic signed [31:0] gmean_reg;

    kind_t kind_reg;
    logic [11:0] u_reg, i_reg;
    logic [6:0] f_reg;
    logic signed [31:0] wv_reg, sc_reg;
    logic [CW-1:0] n_reg;

    logic uok, iok, fac_ok, bias_sel;
    assign uok = ({20'd0, u_reg} < 32'(USERS));
    assign iok = ({20'd0, i_reg} < 32'(ITEMS));
    assign fac_ok = ({25'd0, f_reg} < 32'(MAX_FEATURES));
    assign bias_sel = ({25'd0, f_reg} == 32'(MAX_FEATURES));

    logic [UW-1:0] urow;
    logic [IW-1:0] irow;
    logic [FW-1:0] fsel;
    assign urow = u_reg[UW-1:0];
    assign irow = i_reg[IW-1:0];
    assign fsel = f_reg[FW-1:0];

    // feature pipeline: issue counter, read data valid in the cycle after issue
    logic [CW-1:0] rcnt_reg;
    logic [CW-1:0] wcnt_reg;
    logic rv_reg;
    logic signed [31:0] urd_reg, ird_reg, ubrd_reg, ibrd_reg;
    logic signed [31:0] rd_reg;
    logic signed [71:0] acc_reg;
    logic signed [31:0] pred_reg, err_reg;

    logic issuing;
    assign issuing = (cmd.dot_step || cmd.upd_step) && (rcnt_reg < n_reg);
    logic [FW-1:0] radr, wadr;
    assign radr = rcnt_reg[FW-1:0];
    assign wadr = wcnt_reg[FW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind_t'(kind);
            u_reg <= user_index;
            i_reg <= item_index;
            f_reg <= feature_index;
            wv_reg <= write_value;
            sc_reg <= score;
            n_reg <= ({25'd0, nfeat} > 32'(MAX_FEATURES)) ? CW'(MAX_FEATURES) : CW'(nfeat);
        end
    end

    // update arithmetic: inner differences first, then the step on the next cycle
    logic signed [63:0] eu, ev, ru, rv_p;
    logic signed [47:0] tv, tu;
    logic signed [47:0] tv_reg, tu_reg;
    logic signed [31:0] uo_reg, vo_reg;
    logic rv2_reg;
    logic signed [64:0] dv, du;
    assign eu = err_reg * urd_reg;
    assign ev = err_reg * ird_reg;
    assign ru = $signed({1'b0, rg}) * urd_reg;
    assign rv_p = $signed({1'b0, rg}) * ird_reg;
    assign tv = 48'(eu >>> 16) - 48'(rv_p >>> 16);
    assign tu = 48'(ev >>> 16) - 48'(ru >>> 16);
    assign dv = $signed({1'b0, lr}) * tv_reg;
    assign du = $signed({1'b0, lr}) * tu_reg;

    logic signed [31:0] new_v, new_u;
    assign new_v = sat32(72'(vo_reg) + 72'(dv >>> 16));
    assign new_u = sat32(72'(uo_reg) + 72'(du >>> 16));

    function automatic logic signed [31:0] bstep(input logic signed [31:0] b,
            input logic signed [31:0] e, input logic signed [32:0] pf,
            input logic [15:0] l);
        logic signed [33:0] t;
        logic signed [50:0] q;
        t = 34'(e) - 34'(pf);
        q = $signed({1'b0, l}) * t;
        return sat32(72'(b) + 72'(q >>> 16));
    endfunction

    // regularization terms of the biases, registered ahead of the bias step
    logic signed [48:0] ubp, ibp;
    logic signed [32:0] ubp_reg, ibp_reg;
    assign ubp = $signed({1'b0, rg}) * ubrd_reg;
    assign ibp = $signed({1'b0, rg}) * ibrd_reg;

    logic signed [63:0] prod;
    assign prod = urd_reg * ird_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rcnt_reg <= '0;
            wcnt_reg <= '0;
            rv_reg <= 1'b0;
            rv2_reg <= 1'b0;
        end else begin
            rv_reg <= issuing;
            rv2_reg <= cmd.upd_step && rv_reg;
            if (issuing) rcnt_reg <= rcnt_reg + 1'b1;
            if (cmd.dot_step && rcnt_reg == n_reg && rv_reg) rcnt_reg <= '0;
            if (cmd.upd_step && rv2_reg) wcnt_reg <= wcnt_reg + 1'b1;
        end
        if (issuing) begin
            urd_reg <= umem[{urow, radr}];
            ird_reg <= imem[{irow, radr}];
        end
        if (cmd.upd_step && rv_reg) begin
            tv_reg <= tv;
            tu_reg <= tu;
            uo_reg <= urd_reg;
            vo_reg <= ird_reg;
        end
        if (cmd.bias_rd) begin
            ubrd_reg <= ubmem[urow];
            ibrd_reg <= ibmem[irow];
        end
        if (cmd.dot_clr) acc_reg <= '0;
        if (cmd.dot_step && rv_reg) acc_reg <= acc_reg + 72'(prod >>> 16);
        if (cmd.pred) begin
            pred_reg <= sat32(acc_reg + (use_bias ?
                (72'(gmean_reg) + 72'(ubrd_reg) + 72'(ibrd_reg)) : 72'sd0));
            ubp_reg <= 33'(ubp >>> 16);
            ibp_reg <= 33'(ibp >>> 16);
        end
        if (cmd.err) err_reg <= sat32(72'(sc_reg) - 72'(pred_reg));
        if (cmd.upd_step && rv2_reg) begin
            umem[{urow, wadr}] <= new_u;
            imem[{irow, wadr}] <= new_v;
        end
        if (cmd.bias_upd && use_bias) begin
            ubmem[urow] <= bstep(ubrd_reg, err_reg, ubp_reg, lr);
            ibmem[irow] <= bstep(ibrd_reg, err_reg, ibp_reg, lr);
        end
        // host access
        if (cmd.mem_access) begin
            unique case (kind_reg)
                KIND_WR_USER: begin
                    rd_reg <= '0;
                    if (uok) begin
                        if (fac_ok) umem[{urow, fsel}] <= wv_reg;
                        else if (bias_sel) ubmem[urow] <= wv_reg;
                    end
                end
                KIND_WR_ITEM: begin
                    rd_reg <= '0;
                    if (iok) begin
                        if (fac_ok) imem[{irow, fsel}] <= wv_reg;
                        else if (bias_sel) ibmem[irow] <= wv_reg;
                    end
                end
                KIND_RD_USER: begin
                    if (uok && fac_ok) rd_reg <= umem[{urow, fsel}];
                    else if (uok && bias_sel) rd_reg <= ubmem[urow];
                    else rd_reg <= '0;
                end
                KIND_RD_ITEM: begin
                    if (iok && fac_ok) rd_reg <= imem[{irow, fsel}];
                    else if (iok && bias_sel) rd_reg <= ibmem[irow];
                    else rd_reg <= '0;
                end
                KIND_RD_GLOB: rd_reg <= gmean_reg;
                default: rd_reg <= '0;
            endcase
        end
    end

    logic signed [47:0] ge;
    assign ge = $signed({1'b0, lr}) * err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) gmean_reg <= '0;
        else if (cmd.mem_access && kind_reg == KIND_WR_GLOB) gmean_reg <= wv_reg;
        else if (cmd.bias_upd && use_bias) gmean_reg <= sat32(72'(gmean_reg) + 72'(ge >>> 16));
    end

    logic rating;
    assign rating = (kind_reg == KIND_RATE) && uok && iok;
    always_comb begin
        st.rate_ok = rating;
        st.host_op = (kind_reg != KIND_RATE) && (kind_reg != KIND_NONE);
        st.dot_last = rv_reg && (rcnt_reg == n_reg);
        st.upd_last = rv2_reg && (wcnt_reg + 1'b1 == n_reg);
        st.dot_empty = (n_reg == '0);
    end

    assign res_pred = rating ? pred_reg : 32'sd0;
    assign res_err  = rating ? err_reg : 32'sd0;
    assign res_read = (kind_reg == KIND_RATE) ? 32'sd0 : rd_reg;
endmodule
`default_nettype wire

// ===== src/sgd_matrix_factor_trainer.sv =====
`default_nettype none
// Channel   Ports                                   Direction
// input     s_valid/s_ready, s_kind..s_score        in
// result    m_valid/m_ready, m_prediction..         out
// config    cfg_valid/cfg_ready, cfg_index/data     in
// A rating walks the one-read-port factor memories over N features (N = features used,
// at most MAX_FEATURES, 64 by default; both walks are skipped when N is 0), once for the
// dot product and once, two stages deep, for the update.
// Host reads and writes pass the access, wait and done states, then idle before the next transfer.
// Reset clears the control state, the config registers, the output valid and the global mean;
// tables stay undefined. A stalled result holds the block before it takes the next item.
module sgd_matrix_factor_trainer import smf_pkg::*; #(
    parameter int USERS = 4096,
    parameter int ITEMS = 4096,
    parameter int MAX_FEATURES = 64
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  [2:0]        s_kind,
    input  wire  [11:0]       s_user_index,
    input  wire  [11:0]       s_item_index,
    input  wire  [6:0]        s_feature_index,
    input  wire signed [31:0] s_write_value,
    input  wire signed [31:0] s_score,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [31:0] m_prediction,
    output logic signed [31:0] m_error,
    output logic signed [31:0] m_read_value,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire  [1:0]        cfg_index,
    input  wire  [15:0]       cfg_data
);
    logic [15:0] lr_reg, rg_reg;
    logic [6:0] nf_reg;
    logic ub_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= 16'd655; rg_reg <= 16'd1311; nf_reg <= 7'd16; ub_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LR:    lr_reg <= cfg_data;
                CFG_REG:   rg_reg <= cfg_data;
                CFG_NFEAT: nf_reg <= cfg_data[6:0];
                CFG_BIAS:  ub_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cmd_t cmd;
    stat_t st;
    logic busy, in_fire;
    logic signed [31:0] rp, re, rr;

    assign s_ready = !busy;
    assign in_fire = s_valid && s_ready;

    smf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(m_valid && !m_ready), .st(st), .cmd(cmd), .busy(busy)
    );

    smf_datapath #(.USERS(USERS), .ITEMS(ITEMS), .MAX_FEATURES(MAX_FEATURES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st),
        .kind(s_kind), .user_index(s_user_index), .item_index(s_item_index),
        .feature_index(s_feature_index), .write_value(s_write_value), .score(s_score),
        .lr(lr_reg), .rg(rg_reg), .nfeat(nf_reg), .use_bias(ub_reg),
        .res_pred(rp), .res_err(re), .res_read(rr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (cmd.result) m_valid <= 1'b1;
        else if (m_ready) m_valid <= 1'b0;
        if (cmd.result) begin
            m_prediction <= rp; m_error <= re; m_read_value <= rr;
        end
    end

`include "sgd_matrix_factor_trainer_macros.svh"
    `SMF_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, busy, !in_fire)
    `SMF_ASSERT_IMP(a_result_no_overwrite, aclk, aresetn, m_valid && !m_ready, !cmd.result)
    `SMF_ASSERT_NXT(a_result_valid, aclk, aresetn, cmd.result, m_valid)
endmodule
`default_nettype wire

// ===== dv/sgd_matrix_factor_trainer_tb.sv =====
`timescale 1ns / 1ps

module sgd_matrix_factor_trainer_tb;
    import smf_pkg::*;

    localparam int NF = 64;
    localparam int BIAS_SLOT = 64;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_kind = '0;
    logic [11:0]        s_user_index = '0;
    logic [11:0]        s_item_index = '0;
    logic [6:0]         s_feature_index = '0;
    logic signed [31:0] s_write_value = '0;
    logic signed [31:0] s_score = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_prediction;
    logic signed [31:0] m_error;
    logic signed [31:0] m_read_value;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    sgd_matrix_factor_trainer DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    typedef struct {
        logic signed [31:0] prediction;
        logic signed [31:0] error;
        logic signed [31:0] read_value;
    } outcome_t;

    outcome_t pending_outcomes[$];
    int errors = 0;
    bit no_idle = 0;

    // shadow of the trainer state
    logic signed [31:0] user_fac[int];
    logic signed [31:0] item_fac[int];
    logic signed [31:0] user_bias[int];
    logic signed [31:0] item_bias[int];
    logic signed [31:0] glob_mean;
    logic [15:0] lr_q;
    logic [15:0] reg_q;
    logic [6:0]  nfeat_q;
    logic        bias_on;

    // rows that are fully loaded and safe to rate and read
    logic [11:0] user_pool[4] = '{12'd0, 12'd1, 12'd2, 12'd4095};
    logic [11:0] item_pool[4] = '{12'd0, 12'd1, 12'd2, 12'd4095};
    int written_user_keys[$];
    int written_item_keys[$];

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fl16(longint x);
        return x >>> 16;
    endfunction

    function automatic logic signed [31:0] bias_next(longint b, longint e);
        longint t;
        t = e - fl16(longint'(reg_q) * b);
        return 32'(sat32(b + fl16(longint'(lr_q) * t)));
    endfunction

    function automatic outcome_t trainer_step(logic [2:0] k, logic [11:0] u, logic [11:0] it,
                                              logic [6:0] f, logic signed [31:0] wv,
                                              logic signed [31:0] sc);
        outcome_t o;
        longint acc, e, uo, vo, dv, du, lr, rg;
        int n, ub_key, ib_key;
        o = '{0, 0, 0};
        ub_key = int'(u) * NF;
        ib_key = int'(it) * NF;
        lr = longint'(lr_q);
        rg = longint'(reg_q);
        case (k)
            KIND_RATE: begin
                n = (nfeat_q > NF) ? NF : int'(nfeat_q);
                acc = 0;
                if (bias_on)
                    acc = longint'(glob_mean) + user_bias[u] + item_bias[it];
                for (int i = 0; i < n; i++)
                    acc += fl16(longint'(user_fac[ub_key + i]) * item_fac[ib_key + i]);
                acc = sat32(acc);
                e = sat32(longint'(sc) - acc);
                o.prediction = 32'(acc);
                o.error = 32'(e);
                if (bias_on) begin
                    glob_mean = 32'(sat32(longint'(glob_mean) + fl16(lr * e)));
                    user_bias[u] = bias_next(user_bias[u], e);
                    item_bias[it] = bias_next(item_bias[it], e);
                end
                for (int i = 0; i < n; i++) begin
                    uo = user_fac[ub_key + i];
                    vo = item_fac[ib_key + i];
                    dv = fl16(lr * (fl16(e * uo) - fl16(rg * vo)));
                    du = fl16(lr * (fl16(e * vo) - fl16(rg * uo)));
                    item_fac[ib_key + i] = 32'(sat32(vo + dv));
                    user_fac[ub_key + i] = 32'(sat32(uo + du));
                end
            end
            KIND_WR_USER: begin
                if (f < NF) user_fac[ub_key + f] = wv;
                else if (f == BIAS_SLOT) user_bias[u] = wv;
            end
            KIND_WR_ITEM: begin
                if (f < NF) item_fac[ib_key + f] = wv;
                else if (f == BIAS_SLOT) item_bias[it] = wv;
            end
            KIND_WR_GLOB: glob_mean = wv;
            KIND_RD_USER: begin
                if (f < NF) o.read_value = user_fac[ub_key + f];
                else if (f == BIAS_SLOT) o.read_value = user_bias[u];
            end
            KIND_RD_ITEM: begin
                if (f < NF) o.read_value = item_fac[ib_key + f];
                else if (f == BIAS_SLOT) o.read_value = item_bias[it];
            end
            KIND_RD_GLOB: o.read_value = glob_mean;
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string field, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    // result side: random stall bursts (none once no_idle is set), check each transfer
    int stall_left = 0;
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with nothing outstanding", $realtime);
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_prediction !== want.prediction)
                    report_mismatch("prediction", m_prediction, want.prediction);
                if (m_error !== want.error)
                    report_mismatch("error", m_error, want.error);
                if (m_read_value !== want.read_value)
                    report_mismatch("read_value", m_read_value, want.read_value);
            end
        end
        if (no_idle) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(kind_t k, logic [11:0] u, logic [11:0] it, logic [6:0] f,
                             logic signed [31:0] wv, logic signed [31:0] sc);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_kind <= k;
        s_user_index <= u;
        s_item_index <= it;
        s_feature_index <= f;
        s_write_value <= wv;
        s_score <= sc;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_outcomes.push_back(trainer_step(k, u, it, f, wv, sc));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LR:    lr_q = data;
            CFG_REG:   reg_q = data;
            CFG_NFEAT: nfeat_q = data[6:0];
            default:   bias_on = data[0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(logic [15:0] lr, logic [15:0] rg, logic [6:0] nf, logic b);
        drain();
        write_cfg(CFG_LR, lr);
        write_cfg(CFG_REG, rg);
        write_cfg(CFG_NFEAT, 16'(nf));
        write_cfg(CFG_BIAS, 16'(b));
    endtask

    function automatic logic signed [31:0] modest_value();
        return 32'(int'($urandom_range(0, 262143)) - 131072);
    endfunction

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom);
            default: return modest_value();
        endcase
    endfunction

    task automatic test_load_tables();
        for (int r = 0; r < 4; r++)
            for (int f = 0; f <= BIAS_SLOT; f++) begin
                send_item(KIND_WR_USER, user_pool[r], 12'($urandom), 7'(f), modest_value(), 0);
                send_item(KIND_WR_ITEM, 12'($urandom), item_pool[r], 7'(f), modest_value(), 0);
            end
        send_item(KIND_WR_GLOB, 0, 0, 0, 32'sh00030000, 0);
    endtask

    task automatic test_directed();
        // saturated prediction and error on the extreme rows
        for (int f = 0; f < 4; f++) begin
            send_item(KIND_WR_USER, 12'd4095, 0, 7'(f), 32'sh7fffffff, 0);
            send_item(KIND_WR_ITEM, 0, 12'd4095, 7'(f), 32'sh7fffffff, 0);
        end
        send_item(KIND_RATE, 12'd4095, 12'd4095, 0, 0, 32'sh80000000);
        send_item(KIND_RATE, 12'd4095, 12'd4095, 0, 0, 32'sh7fffffff);
        send_item(KIND_WR_GLOB, 0, 0, 0, 32'sh80000000, 0);
        send_item(KIND_RD_GLOB, 12'hfff, 12'hfff, 7'h7f, 0, 0);
        send_item(KIND_WR_GLOB, 0, 0, 0, 32'sh7fffffff, 0);
        send_item(KIND_RD_GLOB, 0, 0, 0, 0, 0);
        send_item(KIND_RD_USER, 12'd4095, 0, 7'(BIAS_SLOT), 0, 0);
        send_item(KIND_RD_ITEM, 0, 12'd4095, 7'd63, 0, 0);
        // feature index past the bias slot: write dropped, read gives zero
        send_item(KIND_WR_USER, 12'd1, 0, 7'd127, 32'sh12345678, 0);
        send_item(KIND_RD_USER, 12'd1, 0, 7'd127, 0, 0);
        send_item(KIND_RD_ITEM, 0, 12'd1, 7'd65, 0, 0);
        send_item(KIND_NONE, 12'hfff, 12'hfff, 7'h7f, 32'sh7fffffff, 32'sh7fffffff);
        send_item(KIND_RATE, 12'd0, 12'd1, 0, 0, 32'sh00040000);
        send_item(KIND_RD_USER, 12'd0, 0, 7'd20, 0, 0);
        send_item(KIND_RD_GLOB, 0, 0, 0, 0, 0);
        send_item(KIND_WR_GLOB, 0, 0, 0, 32'sh00030000, 0);
    endtask

    task automatic test_config_corners();
        logic [6:0] nf_set[5] = '{7'd0, 7'd1, 7'd64, 7'd100, 7'd127};
        foreach (nf_set[i]) begin
            set_config(i[0] ? 16'hffff : 16'd0, i[1] ? 16'd0 : 16'hffff, nf_set[i], i[0]);
            repeat (3) send_item(KIND_RATE, user_pool[$urandom_range(0, 3)],
                                 item_pool[$urandom_range(0, 3)], 0, 0, any_value());
            send_item(KIND_RD_USER, user_pool[0], 0, 7'(BIAS_SLOT), 0, 0);
            send_item(KIND_RD_ITEM, 0, item_pool[1], 7'd63, 0, 0);
        end
    endtask

    task automatic random_item();
        int sel, key;
        logic [11:0] u, it;
        logic [6:0] f;
        sel = $urandom_range(0, 99);
        u = user_pool[$urandom_range(0, 3)];
        it = item_pool[$urandom_range(0, 3)];
        f = 7'($urandom_range(0, BIAS_SLOT));
        if (sel < 55) begin
            send_item(KIND_RATE, u, it, 7'($urandom), 32'($urandom), any_value());
        end else if (sel < 65) begin
            send_item(KIND_WR_USER, u, 12'($urandom), f, modest_value(), 32'($urandom));
        end else if (sel < 72) begin
            send_item(KIND_WR_ITEM, 12'($urandom), it, f, modest_value(), 32'($urandom));
        end else if (sel < 77) begin
            // arbitrary rows and slots; remember where data landed
            u = 12'($urandom);
            it = 12'($urandom);
            f = 7'($urandom);
            send_item($urandom_range(0, 1) ? KIND_WR_USER : KIND_WR_ITEM, u, it, f,
                      32'($urandom), 32'($urandom));
            if (s_kind == KIND_WR_USER && f < NF) written_user_keys.push_back(u * NF + f);
            if (s_kind == KIND_WR_ITEM && f < NF) written_item_keys.push_back(it * NF + f);
        end else if (sel < 85) begin
            send_item(KIND_RD_USER, u, 12'($urandom), $urandom_range(0, 3) == 0 ?
                      7'($urandom) : f, 32'($urandom), 32'($urandom));
        end else if (sel < 90) begin
            send_item(KIND_RD_ITEM, 12'($urandom), it, f, 32'($urandom), 32'($urandom));
        end else if (sel < 94) begin
            if (written_user_keys.size() != 0) begin
                key = written_user_keys[$urandom_range(0, written_user_keys.size() - 1)];
                send_item(KIND_RD_USER, 12'(key / NF), 0, 7'(key % NF), 0, 0);
            end
            if (written_item_keys.size() != 0) begin
                key = written_item_keys[$urandom_range(0, written_item_keys.size() - 1)];
                send_item(KIND_RD_ITEM, 0, 12'(key / NF), 7'(key % NF), 0, 0);
            end
        end else if (sel < 96) begin
            send_item(KIND_WR_GLOB, 12'($urandom), 12'($urandom), 7'($urandom),
                      any_value(), 32'($urandom));
        end else if (sel < 98) begin
            send_item(KIND_RD_GLOB, 12'($urandom), 12'($urandom), 7'($urandom), 0, 0);
        end else begin
            send_item(KIND_NONE, 12'($urandom), 12'($urandom), 7'($urandom),
                      32'($urandom), 32'($urandom));
        end
    endtask

    task automatic test_random();
        logic [6:0] nf;
        for (int phase = 0; phase < 6; phase++) begin
            nf = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16));
            set_config(16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 4000)),
                       16'($urandom), nf, 1'($urandom));
            if (phase == 5) no_idle = 1;
            repeat (30) random_item();
        end
    endtask

    initial begin
        glob_mean = 0;
        lr_q = 16'd655;
        reg_q = 16'd1311;
        nfeat_q = 7'd16;
        bias_on = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_tables();
        test_directed();
        test_config_corners();
        test_random();
        drain();
        if (errors == 0)
            $display("sgd_matrix_factor_trainer_tb: done, clean");
        else
            $display("sgd_matrix_factor_trainer_tb: done, errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("sgd_matrix_factor_trainer_tb: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/smf_pkg.sv
src/smf_ctrl.sv
src/smf_datapath.sv
src/sgd_matrix_factor_trainer.sv
dv/sgd_matrix_factor_trainer_tb.sv
